[rtl/ccrn_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and tables for the cross-channel response normalizer.
// No dependencies; every other file imports this package.
package ccrn_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SUM_W       = 35;
    localparam int IDX_W       = 10;
    localparam int BASE_W      = 36;
    localparam int MAN_W       = 31;
    localparam int FRAC_W      = 16;
    localparam int TERM_W      = 30;
    localparam int RECIP_W     = 34;
    localparam int ESUM_W      = 31;
    localparam int MAG_W       = SAMPLE_BITS + ESUM_W;
    localparam int EXP_TERMS   = 12;
    localparam int ADDR_W      = 4;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_KAPPA  = 2'd1;
    localparam logic [1:0] REG_ALPHA  = 2'd2;
    localparam logic [1:0] REG_BETA   = 2'd3;

    typedef struct packed {
        logic [3:0]  window_size;
        logic [23:0] kappa_q16;
        logic [31:0] alpha_q24;
        logic [15:0] beta_q14;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [SUM_W-1:0]              sum;
        logic [IDX_W-1:0]              index;
        logic                          done;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [2:0] {
        F_IDLE, F_CHECK, F_PLAN, F_RD, F_ACC, F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE, B_MUL, B_BASE, B_NORM, B_LOG, B_EXPO, B_T,
        B_TERM1, B_TERM2, B_MAG, B_SHIFT, B_OUT
    } t_bstate;

    // ceil(2^34 / n): exact floor division of a value below 2^30 by n
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
        logic [RECIP_W-1:0] v;
        unique case (n)
            4'd2:    v = 34'd8589934592;
            4'd3:    v = 34'd5726623062;
            4'd4:    v = 34'd4294967296;
            4'd5:    v = 34'd3435973837;
            4'd6:    v = 34'd2863311531;
            4'd7:    v = 34'd2454267027;
            4'd8:    v = 34'd2147483648;
            4'd9:    v = 34'd1908874354;
            4'd10:   v = 34'd1717986919;
            4'd11:   v = 34'd1561806290;
            4'd12:   v = 34'd1431655766;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/ccrn_front.sv]
`timescale 1ns / 1ps
// Front end: takes words, keeps the channel ring and sums squares over each window.
// Depends on ccrn_pkg; feeds ccrn_queue.
module ccrn_front #(
    parameter int MAX_WINDOW   = 15,
    parameter int MAX_CHANNELS = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [3:0]                             i_window_size,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [ccrn_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                   i_last_channel,
    input  ccrn_pkg::t_qstat                       i_qstat,
    output logic                                   o_push,
    output ccrn_pkg::t_job                         o_job
);
    import ccrn_pkg::*;

    localparam int RD    = MAX_WINDOW + 1;
    localparam int RA_W  = $clog2(RD);
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int W_W   = ((CNT_W > 6) ? CNT_W : 6) + 1;

    t_fstate r_state, n_state;

    logic signed [SAMPLE_BITS-1:0] r_ring [RD];
    logic signed [SAMPLE_BITS-1:0] r_rdata, r_x;
    logic [RA_W-1:0]  r_wp, r_cur_wp, r_raddr;
    logic [CNT_W-1:0] r_in_cnt, r_out_cnt, r_cur_i, r_j, r_hi;
    logic             r_last;
    logic [3:0]       r_m1, r_m2;
    logic [SUM_W-1:0] r_acc;

    logic [4:0]       w_win, w_wm1;
    logic [W_W-1:0]   w_t, w_i, w_lo1, w_lo2, w_lo, w_hi, w_dist, w_wp;
    logic             w_more, w_acc;
    logic [RA_W-1:0]  w_raddr, w_raddr_inc, w_wp_inc;
    logic signed [2*SAMPLE_BITS-1:0] w_sq;

    assign w_acc      = i_in_valid && (r_state == F_IDLE);
    assign o_in_stall = (r_state != F_IDLE);

    always_comb begin
        if (i_window_size == 4'd0) begin
            w_win = 5'd1;
        end else if ({1'b0, i_window_size} > 5'(MAX_WINDOW)) begin
            w_win = 5'(MAX_WINDOW);
        end else begin
            w_win = {1'b0, i_window_size};
        end
        w_wm1 = w_win - 5'd1;

        w_t   = W_W'(r_out_cnt);
        w_i   = W_W'(r_cur_i);
        w_lo1 = (w_t > W_W'(r_m1)) ? w_t - W_W'(r_m1) : '0;
        w_lo2 = (w_i + W_W'(1) > W_W'(RD)) ? w_i + W_W'(1) - W_W'(RD) : '0;
        w_lo  = (w_lo1 > w_lo2) ? w_lo1 : w_lo2;
        w_hi  = (w_t + W_W'(r_m2) < w_i) ? w_t + W_W'(r_m2) : w_i;
        w_dist = w_i - w_lo;
        w_wp   = W_W'(r_cur_wp);
        w_raddr = (w_wp >= w_dist) ? RA_W'(w_wp - w_dist) : RA_W'(w_wp + W_W'(RD) - w_dist);
        w_raddr_inc = (r_raddr == RA_W'(RD - 1)) ? '0 : r_raddr + RA_W'(1);
        w_wp_inc    = (r_cur_wp == RA_W'(RD - 1)) ? '0 : r_cur_wp + RA_W'(1);
        w_more = r_last ? (w_t <= w_i) : (w_t + W_W'(r_m2) <= w_i);
        w_sq   = r_rdata * r_rdata;
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE:  if (i_in_valid) n_state = F_CHECK;
            F_CHECK: n_state = w_more ? F_PLAN : F_IDLE;
            F_PLAN:  n_state = F_RD;
            F_RD:    n_state = F_ACC;
            F_ACC:   n_state = (r_j == r_hi) ? F_PUSH : F_RD;
            F_PUSH: begin
                if (!i_qstat.full) begin
                    o_push  = 1'b1;
                    n_state = F_CHECK;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign o_job.sample = r_x;
    assign o_job.sum    = r_acc;
    assign o_job.index  = IDX_W'(r_out_cnt);
    assign o_job.done   = r_last && (r_out_cnt == r_cur_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_wp      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_CHECK && !w_more) begin
                if (r_last) begin
                    r_in_cnt  <= '0;
                    r_out_cnt <= '0;
                    r_wp      <= '0;
                end else begin
                    r_in_cnt <= r_cur_i + CNT_W'(1);
                    r_wp     <= w_wp_inc;
                end
            end
            if (o_push) begin
                r_out_cnt <= r_out_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ring[r_wp] <= i_sample;
        end
        r_rdata <= r_ring[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    r_cur_i  <= r_in_cnt;
                    r_cur_wp <= r_wp;
                    r_last   <= i_last_channel || (r_in_cnt >= CNT_W'(MAX_CHANNELS - 1));
                    r_m1     <= 4'(w_wm1 >> 1);
                    r_m2     <= 4'(w_wm1 - (w_wm1 >> 1));
                end
            end
            F_PLAN: begin
                r_j     <= CNT_W'(w_lo);
                r_hi    <= CNT_W'(w_hi);
                r_raddr <= w_raddr;
                r_acc   <= '0;
            end
            F_ACC: begin
                r_acc <= r_acc + SUM_W'($unsigned(w_sq));
                if (r_j == r_out_cnt) r_x <= r_rdata;
                r_j     <= r_j + CNT_W'(1);
                r_raddr <= w_raddr_inc;
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/ccrn_queue.sv]
`timescale 1ns / 1ps
// Two-entry job queue between the window front end and the power unit.
// Depends on ccrn_pkg.
module ccrn_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ccrn_pkg::t_job   i_job,
    input  logic             i_pop,
    output ccrn_pkg::t_job   o_job,
    output ccrn_pkg::t_qstat o_qstat
);
    import ccrn_pkg::*;

    localparam int Q_DEPTH = 2;

    t_job       r_mem [Q_DEPTH];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    assign o_job         = r_mem[r_rptr];
    assign o_qstat.full  = (r_cnt == 2'(Q_DEPTH));
    assign o_qstat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_job;
    end

endmodule

[rtl/ccrn_power.sv]
`timescale 1ns / 1ps
// Power unit: base, log2 by squaring, exp2 series, scaling and saturation; output register.
// Depends on ccrn_pkg; takes jobs from ccrn_queue.
module ccrn_power (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ccrn_pkg::t_cfg                          i_cfg,
    input  ccrn_pkg::t_qstat                        i_qstat,
    input  ccrn_pkg::t_job                          i_job,
    output logic                                    o_pop,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [ccrn_pkg::SAMPLE_BITS-1:0] o_normalized,
    output logic [ccrn_pkg::IDX_W-1:0]              o_channel_index,
    output logic                                    o_pixel_done
);
    import ccrn_pkg::*;

    t_bstate r_state, n_state;

    logic signed [SAMPLE_BITS-1:0] r_x, r_res;
    logic [SUM_W-1:0]   r_sum;
    logic [IDX_W-1:0]   r_idx;
    logic               r_done;
    logic [63:0]        r_plo;
    logic [SUM_W-1:0]   r_phi;
    logic [BASE_W-1:0]  r_m;
    logic [5:0]         r_e;
    logic [MAN_W-1:0]   r_man;
    logic [FRAC_W-1:0]  r_frac;
    logic [3:0]         r_cnt;
    logic signed [39:0] r_e30;
    logic [TERM_W-1:0]  r_t, r_tx;
    logic [TERM_W:0]    r_term;
    logic [ESUM_W-1:0]  r_esum;
    logic [MAG_W-1:0]   r_mag;
    logic               r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_norm;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_done;

    logic [BASE_W-1:0]  w_base;
    logic [61:0]        w_sq;
    logic [31:0]        w_msq;
    logic [MAN_W-1:0]   w_man;
    logic signed [6:0]  w_le;
    logic signed [22:0] w_l;
    logic signed [39:0] w_bl;
    logic [47:0]        w_tprod;
    logic [60:0]        w_txp;
    logic [63:0]        w_qp;
    logic [TERM_W-1:0]  w_q;
    logic [SAMPLE_BITS-1:0] w_abs, w_lim, w_r;
    logic signed [10:0] w_s;
    logic [10:0]        w_nsh;
    logic [MAG_W-1:0]   w_shq;
    logic [MAG_W:0]     w_rr;
    logic               w_neg, w_load;

    always_comb begin
        w_base = BASE_W'(i_cfg.kappa_q16) + BASE_W'(r_phi) + BASE_W'(r_plo[63:32]);
        w_sq   = r_man * r_man;
        w_msq  = w_sq[61:30];
        w_man  = w_msq[31] ? w_msq[31:1] : w_msq[30:0];
        w_le   = $signed({1'b0, r_e}) - 7'sd16;
        w_l    = {w_le, r_frac};
        w_bl   = $signed({1'b0, i_cfg.beta_q14}) * w_l;
        w_tprod = r_e30[29:14] * LN2_Q32;
        w_txp  = r_term * r_t;
        w_qp   = r_tx * recip(r_cnt);
        w_q    = (r_cnt == 4'd1) ? r_tx : w_qp[63:34];
        w_neg  = r_x[SAMPLE_BITS-1];
        w_abs  = w_neg ? SAMPLE_BITS'(-r_x) : SAMPLE_BITS'(r_x);
        w_lim  = w_neg ? SAMPLE_BITS'(1 << (SAMPLE_BITS - 1))
                       : SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
        w_s    = 11'sd30 - $signed({r_e30[39], r_e30[39:30]});
        w_nsh  = 11'(-w_s);
        w_shq  = r_mag >> 11'(w_s - 11'sd1);
        w_rr   = ({1'b0, w_shq} + (MAG_W+1)'(1)) >> 1;
        w_r    = '0;
        if (w_s <= 11'sd0) begin
            if (r_mag == '0) begin
                w_r = '0;
            end else if (w_nsh >= 11'(SAMPLE_BITS)) begin
                w_r = w_lim;
            end else if (r_mag > MAG_W'(w_lim >> w_nsh)) begin
                w_r = w_lim;
            end else begin
                w_r = SAMPLE_BITS'(r_mag) << w_nsh;
            end
        end else if (w_s >= 11'sd63) begin
            w_r = '0;
        end else if (w_rr > (MAG_W+1)'(w_lim)) begin
            w_r = w_lim;
        end else begin
            w_r = SAMPLE_BITS'(w_rr);
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_state = B_MUL;
                end
            end
            B_MUL:   n_state = B_BASE;
            B_BASE:  n_state = (w_base == '0) ? B_OUT : B_NORM;
            B_NORM:  n_state = r_m[BASE_W-1] ? B_LOG : B_NORM;
            B_LOG:   n_state = (r_cnt == 4'(FRAC_W - 1)) ? B_EXPO : B_LOG;
            B_EXPO:  n_state = B_T;
            B_T:     n_state = B_TERM1;
            B_TERM1: n_state = B_TERM2;
            B_TERM2: n_state = (r_cnt == 4'(EXP_TERMS)) ? B_MAG : B_TERM1;
            B_MAG:   n_state = B_SHIFT;
            B_SHIFT: n_state = B_OUT;
            B_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_norm <= r_res;
            r_out_idx  <= r_idx;
            r_out_done <= r_done;
        end
        unique case (r_state)
            B_IDLE: begin
                r_x    <= i_job.sample;
                r_sum  <= i_job.sum;
                r_idx  <= i_job.index;
                r_done <= i_job.done;
            end
            B_MUL: begin
                r_plo <= i_cfg.alpha_q24 * r_sum[31:0];
                r_phi <= SUM_W'(i_cfg.alpha_q24 * r_sum[SUM_W-1:32]);
            end
            B_BASE: begin
                r_m   <= w_base;
                r_e   <= 6'(BASE_W - 1);
                r_res <= '0;
            end
            B_NORM: begin
                if (r_m[BASE_W-1]) begin
                    r_man  <= r_m[BASE_W-1 -: MAN_W];
                    r_frac <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_m <= r_m << 1;
                    r_e <= r_e - 6'd1;
                end
            end
            B_LOG: begin
                r_man  <= w_man;
                r_frac <= {r_frac[FRAC_W-2:0], w_msq[31]};
                r_cnt  <= r_cnt + 4'd1;
            end
            B_EXPO: r_e30 <= -w_bl;
            B_T: begin
                r_t    <= w_tprod[47:18];
                r_term <= (TERM_W+1)'(1) << TERM_W;
                r_esum <= ESUM_W'(1) << TERM_W;
                r_cnt  <= 4'd1;
            end
            B_TERM1: r_tx <= w_txp[59:30];
            B_TERM2: begin
                r_term <= {1'b0, w_q};
                r_esum <= r_esum + ESUM_W'(w_q);
                r_cnt  <= r_cnt + 4'd1;
            end
            B_MAG:   r_mag <= w_abs * r_esum;
            B_SHIFT: r_res <= w_neg ? SAMPLE_BITS'(-w_r) : w_r;
            default: begin
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_normalized    = r_out_norm;
    assign o_channel_index = r_out_idx;
    assign o_pixel_done    = r_out_done;

endmodule

[rtl/cross_channel_response_normalize.sv]
`timescale 1ns / 1ps
// Top level of the cross-channel response normalizer: register file, front end,
// job queue and power unit. Depends on ccrn_pkg, ccrn_front, ccrn_queue, ccrn_power.
//
//  channel | handshake                    | word
//  --------+------------------------------+---------------------------------------
//  in      | i_in_valid / o_in_stall      | i_sample, i_last_channel
//  out     | o_out_valid / i_out_stall    | o_normalized, o_channel_index, o_pixel_done
//  cfg     | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// Front end: takes no new word until it has pushed every result that word completes,
// reading taps through the single ring read port. Power unit: one job at a time via
// leading-one scan, 16 log2 squarings and 12 series terms; a zero base skips to output.
// A two-word queue decouples them; the output register holds a result under stall
// while the next one is computed. Synchronous active-low reset.
module cross_channel_response_normalize #(
    parameter int MAX_WINDOW   = 15,
    parameter int MAX_CHANNELS = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [ccrn_pkg::ADDR_W-1:0]             paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [ccrn_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                    i_last_channel,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [ccrn_pkg::SAMPLE_BITS-1:0] o_normalized,
    output logic [ccrn_pkg::IDX_W-1:0]              o_channel_index,
    output logic                                    o_pixel_done
);
    import ccrn_pkg::*;

    t_cfg   r_cfg;
    t_qstat w_qstat;
    t_job   w_fjob, w_qjob;
    logic   w_push, w_pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_size <= 4'd5;
            r_cfg.kappa_q16   <= 24'd131072;
            r_cfg.alpha_q24   <= 32'd1678;
            r_cfg.beta_q14    <= 16'd12288;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_WINDOW: r_cfg.window_size <= pwdata[3:0];
                REG_KAPPA:  r_cfg.kappa_q16   <= pwdata[23:0];
                REG_ALPHA:  r_cfg.alpha_q24   <= pwdata;
                REG_BETA:   r_cfg.beta_q14    <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WINDOW: prdata = 32'(r_cfg.window_size);
            REG_KAPPA:  prdata = 32'(r_cfg.kappa_q16);
            REG_ALPHA:  prdata = r_cfg.alpha_q24;
            REG_BETA:   prdata = 32'(r_cfg.beta_q14);
        endcase
    end

    ccrn_front #(
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_window_size  (r_cfg.window_size),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_last_channel (i_last_channel),
        .i_qstat        (w_qstat),
        .o_push         (w_push),
        .o_job          (w_fjob)
    );

    ccrn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_qstat (w_qstat)
    );

    ccrn_power u_power (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_qstat         (w_qstat),
        .i_job           (w_qjob),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_normalized    (o_normalized),
        .o_channel_index (o_channel_index),
        .o_pixel_done    (o_pixel_done)
    );

    a_stall_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("front end took a second word without working the first");

    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_qstat.full && w_qstat.empty))
        else $error("queue reports full and empty together");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("job popped from an empty queue");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for cross_channel_response_normalize: streams pixels of
// channel words and compares each result word against an in-bench LRN predictor.
// Depends on ccrn_pkg and the RTL of the block.
module testbench;
    import ccrn_pkg::*;

    localparam int  RING        = 16;
    localparam int  CHAN_LIMIT  = 1024;
    localparam int  SETTLE      = 400;
    localparam longint LIMIT    = 3000000;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } t_word;

    typedef struct {
        logic [15:0] value;
        logic [9:0]  index;
        logic        done;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic signed [15:0] i_sample = '0;
    logic        i_last_channel = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic signed [15:0] o_normalized;
    logic [9:0]  o_channel_index;
    logic        o_pixel_done;

    t_word   pending[$];
    t_result expected[$];

    longint win_cfg = 5, kappa_cfg = 131072, alpha_cfg = 1678, beta_cfg = 12288;
    int     ring_samples[RING];
    int     in_chan = 0, out_chan = 0;

    longint cycles = 0;
    int     errors = 0, words_in = 0, results_out = 0, pixels = 0, reg_writes = 0;
    int     in_gap = 0, out_gap = 0;
    bit     calm = 1'b0;

    cross_channel_response_normalize dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint log2_q16(longint unsigned b);
        int e;
        longint unsigned m;
        longint frac;
        e = 63;
        frac = 0;
        while (e > 0 && b[e] == 1'b0)
            e--;
        m = (e >= 30) ? (b >> (e - 30)) : (b << (30 - e));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(e) - 16) * 65536 + frac;
    endfunction

    function automatic longint unsigned exp2_frac_q30(longint unsigned f);
        longint unsigned t, term, acc;
        t = (f * 64'(LN2_Q32)) >> 18;
        term = 64'd1 << 30;
        acc = term;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * t) >> 30) / longint'(n);
            acc += term;
        end
        return acc;
    endfunction

    function automatic longint floor_div(longint a, longint d);
        if (a >= 0)
            return a / d;
        return -((-a + d - 1) / d);
    endfunction

    function automatic logic [15:0] lrn_value(int x, longint unsigned sq);
        longint unsigned base, mag, lim, r, f;
        longint e30, e16, k, s, sh;
        bit neg;
        neg = x < 0;
        base = 64'(kappa_cfg) + 64'(alpha_cfg) * (sq >> 32)
             + ((64'(alpha_cfg) * (sq & 64'hFFFF_FFFF)) >> 32);
        if (base == 0)
            return 16'd0;
        e30 = -(beta_cfg * log2_q16(base));
        e16 = floor_div(e30, 16384);
        k = floor_div(e16, 65536);
        f = 64'(e16 - k * 65536);
        mag = 64'(neg ? -longint'(x) : longint'(x)) * exp2_frac_q30(f);
        lim = neg ? 64'd32768 : 64'd32767;
        s = 30 - k;
        if (s <= 0) begin
            sh = -s;
            if (mag == 0)
                r = 0;
            else if (sh >= 63 || mag > (lim >> sh))
                r = lim;
            else
                r = mag << sh;
        end else if (s >= 63) begin
            r = 0;
        end else begin
            r = (mag + (64'd1 << (s - 1))) >> s;
        end
        if (r > lim)
            r = lim;
        return neg ? 16'(-longint'(r)) : 16'(r);
    endfunction

    task automatic predict_channels(logic signed [15:0] x, logic last_in);
        int n, m1, m2, lo, hi, cnt, t;
        longint limit;
        longint unsigned acc;
        t_result res;
        bit last;
        last = last_in;
        n = int'(win_cfg);
        if (n == 0) n = 1;
        if (n > 15) n = 15;
        m1 = (n - 1) / 2;
        m2 = n - 1 - m1;
        if (in_chan >= CHAN_LIMIT - 1)
            last = 1'b1;
        ring_samples[in_chan % RING] = x;
        limit = last ? in_chan : in_chan - m2;
        cnt = 0;
        while (out_chan <= limit && cnt < 8) begin
            t = out_chan;
            lo = (t > m1) ? t - m1 : 0;
            hi = (t + m2 < in_chan) ? t + m2 : in_chan;
            if (in_chan + 1 > RING && lo < in_chan + 1 - RING)
                lo = in_chan + 1 - RING;
            acc = 0;
            for (int j = lo; j <= hi; j++)
                acc += 64'(longint'(ring_samples[j % RING]) * ring_samples[j % RING]);
            acc &= (64'd1 << 35) - 1;
            res.value = lrn_value(ring_samples[t % RING], acc);
            res.index = t[9:0];
            res.done  = last && t == in_chan;
            expected.push_back(res);
            out_chan++;
            cnt++;
        end
        if (last) begin
            in_chan = 0;
            out_chan = 0;
        end else begin
            in_chan++;
        end
    endtask

    // feed words from the pending queue, with random gaps
    always @(posedge i_clk) begin : feed
        logic nv;
        nv = i_in_valid;
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_channels(i_sample, i_last_channel);
                words_in++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending.size() > 0) begin
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        in_gap = $urandom_range(0, 6);
                    end else begin
                        i_sample <= pending[0].sample;
                        i_last_channel <= pending[0].last;
                        void'(pending.pop_front());
                        nv = 1'b1;
                    end
                end
            end
            i_in_valid <= nv;
        end
    end

    // check result words and stall the output at random
    always @(posedge i_clk) begin : check
        t_result exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_out++;
                if (expected.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: value %0d index %0d done %0b",
                                 o_normalized, o_channel_index, o_pixel_done);
                end else begin
                    exp_r = expected.pop_front();
                    if (o_normalized !== exp_r.value || o_channel_index !== exp_r.index
                            || o_pixel_done !== exp_r.done) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     $signed(exp_r.value), exp_r.index, exp_r.done,
                                     o_normalized, o_channel_index, o_pixel_done);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(0, 6);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic drain;
        while (pending.size() > 0 || i_in_valid || expected.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WINDOW: win_cfg = longint'(val[3:0]);
            REG_KAPPA:  kappa_cfg = longint'(val[23:0]);
            REG_ALPHA:  alpha_cfg = longint'(val);
            default:    beta_cfg = longint'(val[15:0]);
        endcase
        reg_writes++;
    endtask

    task automatic set_all(logic [3:0] w, logic [23:0] k, logic [31:0] a, logic [15:0] b);
        drain();
        write_reg(REG_WINDOW, 32'(w));
        write_reg(REG_KAPPA, 32'(k));
        write_reg(REG_ALPHA, a);
        write_reg(REG_BETA, 32'(b));
    endtask

    task automatic push_word(logic signed [15:0] s, logic l);
        t_word w;
        w.sample = s;
        w.last = l;
        pending.push_back(w);
        if (l) pixels++;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_wide(logic [31:0] mask, logic [31:0] dflt);
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return mask;
            2:       return dflt;
            default: return $urandom & mask;
        endcase
    endfunction

    initial begin : stimulus
        int len;
        for (int i = 0; i < RING; i++)
            ring_samples[i] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_word(16'sh7FFF, 1'b0);
        push_word(16'sh8000, 1'b0);
        push_word(16'sh0000, 1'b0);
        push_word(16'sh0001, 1'b0);
        push_word(16'shFFFF, 1'b1);
        push_word(16'sh1000, 1'b1);
        // zero base, then window of zero
        set_all(4'd0, 24'd0, 32'd0, 16'd12288);
        push_word(16'sh4000, 1'b0);
        push_word(16'shC000, 1'b1);
        set_all(4'd15, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
        for (int i = 0; i < 9; i++)
            push_word(rand_sample(), i == 8);
        set_all(4'd3, 24'd1, 32'hFFFFFFFF, 16'd16384);
        for (int i = 0; i < 4; i++)
            push_word(rand_sample(), 1'b0);
        // widen the window halfway through a pixel
        drain();
        write_reg(REG_WINDOW, 32'd9);
        for (int i = 0; i < 5; i++)
            push_word(rand_sample(), i == 4);

        set_all(4'd5, 24'd131072, 32'd1678, 16'd12288);
        while (words_in + pending.size() < 290) begin
            if ($urandom_range(0, 3) == 0)
                set_all(4'($urandom_range(0, 15)), 24'(rand_wide(32'hFFFFFF, 32'd131072)),
                        rand_wide(32'hFFFFFFFF, 32'd1678),
                        16'(rand_wide(32'hFFFF, 32'd12288)));
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++)
                push_word(rand_sample(), i == len - 1);
        end

        drain();
        calm = 1'b1;
        for (int p = 0; p < 4; p++) begin
            len = $urandom_range(5, 12);
            for (int i = 0; i < len; i++)
                push_word(rand_sample(), i == len - 1);
        end
        drain();

        $display("%0d channel words in %0d pixels, %0d results checked, %0d register writes",
                 words_in, pixels, results_out, reg_writes);
        $display("windows 0 to 15, zero base and saturating extremes covered");
        if (errors == 0 && expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule
